>>> rtl/core/lsd_pkg.sv
// shared types and constants for the lsb stego deframer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package lsd_pkg;

	localparam int LENGTH_BITS = 32;
	localparam int BIT_CNT_W   = $clog2(LENGTH_BITS) + 1;
	localparam int BIT_IDX_W   = $clog2(LENGTH_BITS);
	localparam int CHAR_BITS   = 8;
	localparam int MAGIC_MAX   = 8;

	localparam int HDR_W       = 16;
	localparam int MLEN_W      = 4;
	localparam int MVAL_W      = 64;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 64;

	localparam logic [HDR_W-1:0]  HEADER_BYTES_RST = 16'd54;
	localparam logic [MLEN_W-1:0] MAGIC_LENGTH_RST = 4'd2;
	localparam logic [MVAL_W-1:0] MAGIC_VALUE_RST  = 64'd10787;

	localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_VALUE  = 2'd2;

	localparam logic [2:0] FK_MAGIC   = 3'd0;
	localparam logic [2:0] FK_EXTLEN  = 3'd1;
	localparam logic [2:0] FK_EXT     = 3'd2;
	localparam logic [2:0] FK_FILELEN = 3'd3;
	localparam logic [2:0] FK_DATA    = 3'd4;

	typedef enum logic [2:0] {
		PH_HEADER  = 3'd0,
		PH_MAGIC   = 3'd1,
		PH_EXTLEN  = 3'd2,
		PH_EXT     = 3'd3,
		PH_FILELEN = 3'd4,
		PH_DATA    = 3'd5,
		PH_DONE    = 3'd6
	} phase_t;

	typedef struct packed {
		logic [2:0]  field_kind;
		logic [31:0] field_value;
		logic        magic_ok;
		logic        frame_last;
	} result_t;

endpackage
`default_nettype wire

>>> rtl/core/lsb_stego_deframer.sv
// Image bytes are taken one per cycle, back to back, while item_stall is low; a result goes
// to the result register, or to the skid entry while that register is held, so the input
// keeps flowing while a result waits, and item_stall rises only when both entries are full.
// After header_bytes skipped bytes, bit 0 of each byte is gathered lsb first into 8-bit
// characters and LENGTH_BITS-bit lengths: magic characters, extension length, extension
// characters, file length and data bytes, each reported as one transaction. A restart item
// clears the frame state and keeps the configuration. The configuration port is always ready.
// depends on lsd_pkg
`timescale 1ns / 1ps
`default_nettype none
module lsb_stego_deframer (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                item_valid,
	output logic                                     item_stall,
	input  wire logic                                kind,
	input  wire logic [7:0]                          byte_in,
	output logic                                     result_valid,
	input  wire logic                                result_stall,
	output logic [2:0]                               field_kind,
	output logic [31:0]                              field_value,
	output logic                                     magic_ok,
	output logic                                     frame_last,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [lsd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [lsd_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int LB = lsd_pkg::LENGTH_BITS;
	localparam int BW = lsd_pkg::BIT_CNT_W;

	logic [lsd_pkg::HDR_W-1:0]  header_bytes_q;
	logic [lsd_pkg::MLEN_W-1:0] magic_length_q;
	logic [lsd_pkg::MVAL_W-1:0] magic_value_q;

	lsd_pkg::phase_t            phase_q, phase_d, ph_work;
	logic [lsd_pkg::HDR_W-1:0]  header_count_q, header_count_d;
	logic [BW-1:0]              bit_count_q, bit_count_d;
	logic [LB-1:0]              acc_q, acc_d;
	logic [LB-1:0]              item_count_q, item_count_d;
	logic [LB-1:0]              ext_len_q, ext_len_d;
	logic [LB-1:0]              pay_len_q, pay_len_d;
	logic                       magic_match_q, magic_match_d;

	logic                       out_v_q, skid_v_q;
	lsd_pkg::result_t           out_q, skid_q, res;
	logic                       res_v;

	logic                       item_acc, out_take, active, hdr_wait, done;
	logic [lsd_pkg::MLEN_W-1:0] eff_len;
	logic [BW-1:0]              width, nb;
	logic [LB-1:0]              acc_new, item_inc;
	logic [7:0]                 expect_byte;
	logic                       magic_hit;

	assign cfg_ready  = 1'b1;
	assign item_stall = skid_v_q;
	assign item_acc   = item_valid && !skid_v_q;
	assign out_take   = out_v_q && !result_stall;

	assign result_valid = out_v_q;
	assign field_kind   = out_q.field_kind;
	assign field_value  = out_q.field_value;
	assign magic_ok     = out_q.magic_ok;
	assign frame_last   = out_q.frame_last;

	always_comb begin
		eff_len = (magic_length_q > lsd_pkg::MLEN_W'(lsd_pkg::MAGIC_MAX))
			? lsd_pkg::MLEN_W'(lsd_pkg::MAGIC_MAX) : magic_length_q;
		case (phase_q)
			lsd_pkg::PH_HEADER, lsd_pkg::PH_MAGIC, lsd_pkg::PH_EXTLEN,
			lsd_pkg::PH_EXT, lsd_pkg::PH_FILELEN, lsd_pkg::PH_DATA: active = 1'b1;
			default: active = 1'b0;
		endcase
		hdr_wait = (phase_q == lsd_pkg::PH_HEADER) && (header_count_q < header_bytes_q);
		if (phase_q == lsd_pkg::PH_HEADER) begin
			ph_work = (eff_len != '0) ? lsd_pkg::PH_MAGIC : lsd_pkg::PH_EXTLEN;
		end else begin
			ph_work = phase_q;
		end
		width = (ph_work == lsd_pkg::PH_EXTLEN || ph_work == lsd_pkg::PH_FILELEN)
			? BW'(LB) : BW'(lsd_pkg::CHAR_BITS);
		acc_new     = acc_q | (LB'(byte_in[0]) << bit_count_q[lsd_pkg::BIT_IDX_W-1:0]);
		nb          = bit_count_q + BW'(1);
		done        = (nb >= width);
		item_inc    = item_count_q + LB'(1);
		expect_byte = magic_value_q[8*item_count_q[2:0] +: 8];
		magic_hit   = (acc_new == LB'(expect_byte));

		phase_d        = phase_q;
		header_count_d = header_count_q;
		bit_count_d    = bit_count_q;
		acc_d          = acc_q;
		item_count_d   = item_count_q;
		ext_len_d      = ext_len_q;
		pay_len_d      = pay_len_q;
		magic_match_d  = magic_match_q;
		res_v          = 1'b0;
		res.field_kind  = lsd_pkg::FK_DATA;
		res.field_value = 32'(acc_new);
		res.magic_ok    = 1'b0;
		res.frame_last  = 1'b0;

		if (item_acc) begin
			if (kind) begin
				phase_d        = lsd_pkg::PH_HEADER;
				header_count_d = '0;
				bit_count_d    = '0;
				acc_d          = '0;
				item_count_d   = '0;
				ext_len_d      = '0;
				pay_len_d      = '0;
				magic_match_d  = 1'b1;
			end else if (active && hdr_wait) begin
				header_count_d = header_count_q + lsd_pkg::HDR_W'(1);
			end else if (active) begin
				phase_d = ph_work;
				if (!done) begin
					bit_count_d = nb;
					acc_d       = acc_new;
				end else begin
					bit_count_d = '0;
					acc_d       = '0;
					res_v       = 1'b1;
					case (ph_work)
						lsd_pkg::PH_MAGIC: begin
							res.field_kind = lsd_pkg::FK_MAGIC;
							if (!magic_hit) magic_match_d = 1'b0;
							item_count_d = item_inc;
							if (item_inc >= LB'(eff_len)) begin
								res.magic_ok = magic_match_q && magic_hit;
								phase_d      = lsd_pkg::PH_EXTLEN;
								item_count_d = '0;
							end
						end
						lsd_pkg::PH_EXTLEN: begin
							res.field_kind = lsd_pkg::FK_EXTLEN;
							ext_len_d      = acc_new;
							item_count_d   = '0;
							phase_d = (acc_new != '0) ? lsd_pkg::PH_EXT : lsd_pkg::PH_FILELEN;
						end
						lsd_pkg::PH_EXT: begin
							res.field_kind = lsd_pkg::FK_EXT;
							item_count_d   = item_inc;
							if (item_inc >= ext_len_q) begin
								phase_d      = lsd_pkg::PH_FILELEN;
								item_count_d = '0;
							end
						end
						lsd_pkg::PH_FILELEN: begin
							res.field_kind = lsd_pkg::FK_FILELEN;
							pay_len_d      = acc_new;
							item_count_d   = '0;
							if (acc_new != '0) begin
								phase_d = lsd_pkg::PH_DATA;
							end else begin
								phase_d        = lsd_pkg::PH_DONE;
								res.frame_last = 1'b1;
							end
						end
						default: begin
							res.field_kind = lsd_pkg::FK_DATA;
							item_count_d   = item_inc;
							if (item_inc >= pay_len_q) begin
								phase_d        = lsd_pkg::PH_DONE;
								res.frame_last = 1'b1;
							end
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_bytes_q <= lsd_pkg::HEADER_BYTES_RST;
			magic_length_q <= lsd_pkg::MAGIC_LENGTH_RST;
			magic_value_q  <= lsd_pkg::MAGIC_VALUE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lsd_pkg::CFG_HEADER_BYTES: header_bytes_q <= cfg_data[lsd_pkg::HDR_W-1:0];
				lsd_pkg::CFG_MAGIC_LENGTH: magic_length_q <= cfg_data[lsd_pkg::MLEN_W-1:0];
				lsd_pkg::CFG_MAGIC_VALUE:  magic_value_q  <= cfg_data[lsd_pkg::MVAL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= lsd_pkg::PH_HEADER;
			header_count_q <= '0;
			bit_count_q    <= '0;
			acc_q          <= '0;
			item_count_q   <= '0;
			ext_len_q      <= '0;
			pay_len_q      <= '0;
			magic_match_q  <= 1'b1;
		end else begin
			phase_q        <= phase_d;
			header_count_q <= header_count_d;
			bit_count_q    <= bit_count_d;
			acc_q          <= acc_d;
			item_count_q   <= item_count_d;
			ext_len_q      <= ext_len_d;
			pay_len_q      <= pay_len_d;
			magic_match_q  <= magic_match_d;
		end
	end

	// output register with skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_take || !out_v_q) begin
			out_v_q  <= skid_v_q || res_v;
			skid_v_q <= 1'b0;
		end else if (res_v) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take || !out_v_q) begin
			out_q <= skid_v_q ? skid_q : res;
		end else if (res_v) begin
			skid_q <= res;
		end
	end

endmodule
`default_nettype wire
